[rtl/core/lsdc_pkg.sv]
// Shared constants, tables and pipeline depths of the damage energy block.
package lsdc_pkg;

  // Register indexes of the configuration port.
  typedef enum logic [1:0] {
    CFG_ENERGY_FACTOR = 2'd0,
    CFG_LOSS_FACTOR   = 2'd1,
    CFG_THRESHOLD     = 2'd2,
    CFG_NRT_DIVISOR   = 2'd3
  } cfg_idx_e;

  localparam logic [31:0] ONE_Q30    = 32'h4000_0000;
  localparam logic [31:0] COEF_A_Q30 = 32'd3651581195;
  localparam logic [31:0] COEF_B_Q30 = 32'd432116660;
  localparam logic [21:0] RECIP_6    = 22'd2796203;  // ceil(2^24 / 6)

  localparam int DIV_W     = 53;
  localparam int DIV_STEPS = 32;
  localparam int SQ_STEPS  = 16;
  localparam int POW_LAT   = 36;
  localparam int PIPE_LAT  = 108;

  typedef logic [30:0] exp_tab_t [SQ_STEPS];

  function automatic logic [63:0] isqrt64(logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = v_in;
    r = '0;
    b = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (b > v) b = b >> 2;
    end
    for (int i = 0; i < 32; i++) begin
      if (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
    end
    return r;
  endfunction

  // Entry k holds 2^(2^-(k+1)) in Q1.30, each a floor square root of the one before.
  function automatic exp_tab_t exp_table();
    exp_tab_t t;
    logic [63:0] w;
    w = isqrt64(64'h2000_0000_0000_0000);
    t[0] = w[30:0];
    for (int k = 1; k < SQ_STEPS; k++) begin
      w = isqrt64({3'b0, t[k-1], 30'b0});
      t[k] = w[30:0];
    end
    return t;
  endfunction

  localparam exp_tab_t EXP_TAB = exp_table();

endpackage

[rtl/core/lsdc_pow.sv]
// Pipelined x^(1/6) and x^(3/4) of a UQ16.16 value through log2 and exp2.
module lsdc_pow import lsdc_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] x_i,
  output logic [31:0] p6_o,
  output logic [31:0] p34_o
);

  // Normalization of the input to a Q1.30 mantissa.
  logic [4:0]  nrm_p;
  logic [31:0] nrm_s;

  always_comb begin
    nrm_p = '0;
    for (int i = 0; i < 32; i++) begin
      if (x_i[i]) nrm_p = 5'(i);
    end
    nrm_s = x_i << (5'd31 - nrm_p);
  end

  logic [30:0] m_q  [SQ_STEPS+1];
  logic [15:0] fr_q [SQ_STEPS+1];
  logic [4:0]  lp_q [SQ_STEPS+1];
  logic        z_q  [SQ_STEPS+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q[0]  <= nrm_s[31:1];
      fr_q[0] <= '0;
      lp_q[0] <= nrm_p;
      z_q[0]  <= (x_i == '0);
    end
  end

  // One fraction bit of the logarithm per stage by squaring the mantissa.
  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sq
    logic [61:0] sq;
    logic [15:0] fr_d;
    always_comb begin
      sq = 62'(m_q[k]) * 62'(m_q[k]);
      fr_d = fr_q[k];
      fr_d[SQ_STEPS-1-k] = sq[61];
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        m_q[k+1]  <= sq[61] ? sq[61:31] : sq[60:30];
        fr_q[k+1] <= fr_d;
        lp_q[k+1] <= lp_q[k];
        z_q[k+1]  <= z_q[k];
      end
    end
  end

  // Exponent scaling: l/6 through a reciprocal, 3*l/4 through a shift.
  logic signed [20:0] lg;
  logic signed [22:0] t3;
  logic signed [22:0] y34_full;
  logic [20:0]        lg_abs;

  always_comb begin
    lg       = signed'({lp_q[SQ_STEPS] - 5'd16, fr_q[SQ_STEPS]});
    t3       = (23'(lg) <<< 1) + 23'(lg);
    y34_full = t3[22] ? -(23'((-t3) >> 2)) : (t3 >>> 2);
    lg_abs   = lg[20] ? 21'(-lg) : 21'(lg);
  end

  logic [42:0]        y6p_q;
  logic               y6n_q;
  logic signed [20:0] y34a_q;
  logic               zy_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      y6p_q  <= 43'(lg_abs) * 43'(RECIP_6);
      y6n_q  <= lg[20];
      y34a_q <= y34_full[20:0];
      zy_q   <= z_q[SQ_STEPS];
    end
  end

  logic [20:0] y6_mag;
  assign y6_mag = {2'b00, y6p_q[42:24]};

  // Lane 0 computes 2^(l/6), lane 1 computes 2^(3l/4).
  logic [30:0] r_q  [2][SQ_STEPS+1];
  logic [20:0] y_q  [2][SQ_STEPS+1];
  logic        ze_q [SQ_STEPS+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0][0] <= ONE_Q30[30:0];
      r_q[1][0] <= ONE_Q30[30:0];
      y_q[0][0] <= y6n_q ? 21'(-y6_mag) : y6_mag;
      y_q[1][0] <= y34a_q;
      ze_q[0]   <= zy_q;
    end
  end

  for (genvar ln = 0; ln < 2; ln++) begin : g_lane
    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_exp
      logic [61:0] pr;
      assign pr = 62'(r_q[ln][k]) * 62'(EXP_TAB[k]);
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          r_q[ln][k+1] <= y_q[ln][k][SQ_STEPS-1-k] ? pr[60:30] : r_q[ln][k];
          y_q[ln][k+1] <= y_q[ln][k];
        end
      end
    end
  end

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_zd
    always_ff @(posedge clk_i) begin
      if (en_i) ze_q[k+1] <= ze_q[k];
    end
  end

  // Scale by the integer part of the exponent to UQ16.16.
  logic [31:0] pw [2];

  for (genvar ln = 0; ln < 2; ln++) begin : g_out
    logic signed [5:0] sh;
    always_comb begin
      sh = 6'sd14 - 6'(signed'(y_q[ln][SQ_STEPS][20:16]));
      if (ze_q[SQ_STEPS]) begin
        pw[ln] = '0;
      end else if (sh < 0) begin
        pw[ln] = {r_q[ln][SQ_STEPS], 1'b0};
      end else begin
        pw[ln] = 32'(r_q[ln][SQ_STEPS] >> sh);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p6_o  <= pw[0];
      p34_o <= pw[1];
    end
  end

endmodule

[rtl/core/lsdc_div.sv]
// Pipelined restoring divider giving a 32-bit quotient, one bit per stage.
module lsdc_div import lsdc_pkg::*; (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [DIV_W-1:0] rem_i,
  input  logic [31:0]      low_i,
  input  logic [DIV_W-1:0] den_i,
  output logic [31:0]      quo_o
);

  logic [DIV_W-1:0] rem_q [DIV_STEPS];
  logic [DIV_W-1:0] den_q [DIV_STEPS];
  logic [31:0]      low_q [DIV_STEPS];
  logic [31:0]      quo_q [DIV_STEPS];

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
    logic [DIV_W-1:0] rem_in;
    logic [DIV_W-1:0] den_in;
    logic [31:0]      low_in;
    logic [31:0]      quo_in;
    logic [DIV_W:0]   t;
    logic             ge;

    if (i == 0) begin : g_first
      assign rem_in = rem_i;
      assign den_in = den_i;
      assign low_in = low_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[i-1];
      assign den_in = den_q[i-1];
      assign low_in = low_q[i-1];
      assign quo_in = quo_q[i-1];
    end

    assign t  = {rem_in, low_in[31]};
    assign ge = (t >= {1'b0, den_in});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i] <= ge ? DIV_W'(t - {1'b0, den_in}) : t[DIV_W-1:0];
        den_q[i] <= den_in;
        low_q[i] <= {low_in[30:0], 1'b0};
        quo_q[i] <= {quo_in[30:0], ge};
      end
    end
  end

  assign quo_o = quo_q[DIV_STEPS-1];

endmodule

[rtl/core/lss_damage_energy_nrt_count.sv]
// Top level: damage energy and NRT displacement count of one recoil per request.
//
// Each request carries one recoil energy and produces exactly one result with the
// damage energy (Robinson form of the LSS partition) and the NRT displacement
// count. The block is a 108-stage pipeline that takes one request per cycle while
// its output is not stalled: the reduced energy product, 16 log2 squaring stages,
// 16 exp2 stages for the two fractional powers, the stopping polynomial, and two
// 32-stage restoring dividers (one for the damage energy, one for the count). The
// whole pipeline advances as one: it moves whenever the output register is empty
// or its result is being taken, so a stalled output freezes every stage and
// nothing is lost or repeated.
// Configuration registers must only be written while no request is in flight.
module lss_damage_energy_nrt_count import lsdc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [39:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] recoil_energy_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] damage_energy_o,
  output logic [31:0] displacements_o
);

  // Configuration registers.
  logic [39:0] efact_q;
  logic [31:0] kd_q;
  logic [23:0] thr_q;
  logic [23:0] ndiv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      efact_q <= '0;
      kd_q    <= '0;
      thr_q   <= '0;
      ndiv_q  <= 24'd256;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_ENERGY_FACTOR: efact_q <= cfg_data_i;
        CFG_LOSS_FACTOR:   kd_q    <= cfg_data_i[31:0];
        CFG_THRESHOLD:     thr_q   <= cfg_data_i[23:0];
        CFG_NRT_DIVISOR:   ndiv_q  <= cfg_data_i[23:0];
        default: ;
      endcase
    end
  end

  // The pipeline advances unless a finished result is held by the receiver.
  logic                adv;
  logic [PIPE_LAT-1:0] vld_q;

  assign adv         = !(vld_q[PIPE_LAT-1] && out_stall_i);
  assign in_stall_o  = !adv;
  assign out_valid_o = vld_q[PIPE_LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[PIPE_LAT-2:0], in_valid_i};
    end
  end

  // Reduced energy: the 40-bit factor is split so each product stays narrow.
  logic [51:0] plo_q;
  logic [51:0] phi_q;
  logic [31:0] e1_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      plo_q <= 52'(recoil_energy_i) * 52'(efact_q[19:0]);
      phi_q <= 52'(recoil_energy_i) * 52'(efact_q[39:20]);
      e1_q  <= recoil_energy_i;
    end
  end

  logic [52:0] xmix;
  logic [40:0] xr;
  logic [31:0] x2_q;
  logic [31:0] e2_q;

  always_comb begin
    xmix = 53'({phi_q[11:0], 20'b0}) + 53'(plo_q);
    xr   = 41'(phi_q[51:12]) + 41'(xmix[52:32]);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      x2_q <= (xr[40:32] != '0) ? 32'hFFFF_FFFF : xr[31:0];
      e2_q <= e1_q;
    end
  end

  // Fractional powers of the reduced energy.
  logic [31:0] p6;
  logic [31:0] p34;

  lsdc_pow u_pow (
    .clk_i (clk_i),
    .en_i  (adv),
    .x_i   (x2_q),
    .p6_o  (p6),
    .p34_o (p34)
  );

  // Energy and reduced energy travel alongside the power unit.
  logic [31:0] xd_q [POW_LAT];
  logic [31:0] ed_q [POW_LAT];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      xd_q[0] <= x2_q;
      ed_q[0] <= e2_q;
      for (int i = 1; i < POW_LAT; i++) begin
        xd_q[i] <= xd_q[i-1];
        ed_q[i] <= ed_q[i-1];
      end
    end
  end

  // Weighted power terms, then g in Q.16.
  logic [63:0] ta_full;
  logic [63:0] tb_full;
  logic [33:0] ta_q;
  logic [33:0] tb_q;
  logic [31:0] x3_q;
  logic [31:0] e3_q;

  assign ta_full = 64'(COEF_A_Q30) * 64'(p6);
  assign tb_full = 64'(COEF_B_Q30) * 64'(p34);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ta_q <= ta_full[63:30];
      tb_q <= tb_full[63:30];
      x3_q <= xd_q[POW_LAT-1];
      e3_q <= ed_q[POW_LAT-1];
    end
  end

  logic [35:0] g_q;
  logic [31:0] e4_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      g_q  <= 36'(x3_q) + 36'(ta_q) + 36'(tb_q);
      e4_q <= e3_q;
    end
  end

  // Denominator 1 + kd*g in Q.30, with kd*g split at the binary point of g.
  logic [51:0] pgh_q;
  logic [47:0] pgl_q;
  logic [31:0] e5_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pgh_q <= 52'(kd_q) * 52'(g_q[35:16]);
      pgl_q <= 48'(kd_q) * 48'(g_q[15:0]);
      e5_q  <= e4_q;
    end
  end

  logic [DIV_W-1:0] d_q;
  logic [31:0]      e6_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d_q  <= DIV_W'(ONE_Q30) + DIV_W'(pgh_q) + DIV_W'(pgl_q[47:16]);
      e6_q <= e5_q;
    end
  end

  // Damage energy E*2^30 / D. The top 30 dividend bits start as the remainder,
  // which is below D because D is at least 2^30.
  logic [31:0] tdam;

  lsdc_div u_div_tdam (
    .clk_i (clk_i),
    .en_i  (adv),
    .rem_i (DIV_W'(e6_q[31:2])),
    .low_i ({e6_q[1:0], 30'b0}),
    .den_i (d_q),
    .quo_o (tdam)
  );

  // Threshold check and overflow check of the count before the second division.
  logic [31:0] tdam_q;
  logic        below_q;
  logic        sat_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      tdam_q  <= tdam;
      below_q <= (tdam < {8'b0, thr_q});
      sat_q   <= ({12'b0, tdam[31:20]} >= ndiv_q);
    end
  end

  logic [31:0] cnt;

  lsdc_div u_div_cnt (
    .clk_i (clk_i),
    .en_i  (adv),
    .rem_i (DIV_W'(tdam_q[31:20])),
    .low_i ({tdam_q[19:0], 12'b0}),
    .den_i (DIV_W'(ndiv_q)),
    .quo_o (cnt)
  );

  logic [31:0] td_q [DIV_STEPS];
  logic        bl_q [DIV_STEPS];
  logic        st_q [DIV_STEPS];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      td_q[0] <= tdam_q;
      bl_q[0] <= below_q;
      st_q[0] <= sat_q;
      for (int i = 1; i < DIV_STEPS; i++) begin
        td_q[i] <= td_q[i-1];
        bl_q[i] <= bl_q[i-1];
        st_q[i] <= st_q[i-1];
      end
    end
  end

  // Output register: below threshold gives zero, overflow saturates, and a
  // count under one displacement is raised to one.
  logic [31:0] cnt_d;

  always_comb begin
    if (bl_q[DIV_STEPS-1]) begin
      cnt_d = '0;
    end else if (st_q[DIV_STEPS-1]) begin
      cnt_d = 32'hFFFF_FFFF;
    end else if (cnt < 32'd4096) begin
      cnt_d = 32'd4096;
    end else begin
      cnt_d = cnt;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      damage_energy_o <= td_q[DIV_STEPS-1];
      displacements_o <= cnt_d;
    end
  end

  // An accepted request enters the first stage.
  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> vld_q[0])
    else $error("accepted request did not enter the pipeline");

  // A held output freezes every stage.
  a_stall_freezes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> $stable(vld_q))
    else $error("pipeline moved while the output was held");

  // A nonzero count is never below one displacement.
  a_count_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (displacements_o != '0) |-> displacements_o >= 32'd4096)
    else $error("nonzero displacement count below one");

endmodule

[sim/tb.sv]
// Testbench for lss_damage_energy_nrt_count: damage energy and NRT count checks.
module tb import lsdc_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // One predicted result of the block: damage energy and NRT displacement count.
  typedef struct packed {
    logic [31:0] damage;
    logic [31:0] count;
  } dmg_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_index_i;
  logic [39:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [31:0] recoil_energy_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [31:0] damage_energy_o;
  logic [31:0] displacements_o;

  lss_damage_energy_nrt_count u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .recoil_energy_i (recoil_energy_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .damage_energy_o (damage_energy_o),
    .displacements_o (displacements_o)
  );

  // Shadow copy of the configuration registers, reset values included.
  logic [39:0] sh_energy_factor = '0;
  logic [31:0] sh_loss_factor   = '0;
  logic [23:0] sh_threshold     = '0;
  logic [23:0] sh_divisor       = 24'd256;

  // Q1.30 factors 2^(2^-k) for k = 1..16, each the floor square root of the one before.
  logic [63:0] root_tab [1:16];

  dmg_result_t damage_expect_q [$];
  int          fail_count;
  int          requests_sent;
  int          results_seen;
  int          out_stall_left;
  bit          idle_enable;

  function automatic logic [63:0] int_sqrt(logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = v_in;
    r = '0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Signed Q.16 log2 of a nonzero UQ16.16 value, fraction by repeated squaring.
  function automatic longint log2_fixed(logic [31:0] x);
    int          p;
    logic [63:0] m;
    logic [15:0] fr;
    p = 31;
    fr = '0;
    while (p > 0 && !x[p]) p--;
    if (p <= 30) m = 64'(x) << (30 - p);
    else m = 64'(x) >> 1;
    for (int i = 15; i >= 0; i--) begin
      m = (m * m) >> 30;
      if (m >= 64'h8000_0000) begin
        m = m >> 1;
        fr[i] = 1'b1;
      end
    end
    return longint'(p - 16) * 65536 + longint'(fr);
  endfunction

  // UQ16.16 value of 2^y for signed Q.16 y, saturating to all ones in 64 bits.
  function automatic logic [63:0] exp2_fixed(longint y);
    longint      n;
    longint      f;
    longint      s;
    logic [63:0] fb;
    logic [63:0] r;
    if (y >= 0) n = y / 65536;
    else n = -((-y + 65535) / 65536);
    f = y - n * 65536;
    fb = f;
    r = 64'h4000_0000;
    for (int k = 1; k <= 16; k++) begin
      if (fb[16-k]) r = (r * root_tab[k]) >> 30;
    end
    s = 14 - n;
    if (s >= 63) return '0;
    if (s >= 0) return r >> s;
    if (-s > 32) return '1;
    return r << (-s);
  endfunction

  // Damage energy (Robinson partition) and NRT count for one recoil energy.
  function automatic dmg_result_t predict_damage(logic [31:0] e_in);
    logic [63:0] e;
    logic [63:0] plo;
    logic [63:0] phi;
    logic [63:0] xr;
    logic [63:0] g;
    logic [63:0] p1;
    logic [63:0] p2;
    logic [63:0] d;
    logic [63:0] tdam;
    logic [63:0] cnt;
    longint      l;
    dmg_result_t res;
    e = 64'(e_in);
    plo = e * 64'(sh_energy_factor[19:0]);
    phi = e * 64'(sh_energy_factor[39:20]);
    xr = (phi >> 12) + ((((phi & 64'hFFF) << 20) + plo) >> 32);
    if (xr > 64'hFFFF_FFFF) xr = 64'hFFFF_FFFF;
    g = '0;
    if (xr != 0) begin
      l = log2_fixed(xr[31:0]);
      p1 = exp2_fixed(l / 6);
      p2 = exp2_fixed((l * 3) / 4);
      if (p1 > 64'hFFFF_FFFF) p1 = 64'hFFFF_FFFF;
      if (p2 > 64'hFFFF_FFFF) p2 = 64'hFFFF_FFFF;
      g = xr + ((64'(COEF_A_Q30) * p1) >> 30) + ((64'(COEF_B_Q30) * p2) >> 30);
    end
    d = 64'(ONE_Q30) + 64'(sh_loss_factor) * (g >> 16)
        + ((64'(sh_loss_factor) * (g & 64'hFFFF)) >> 16);
    tdam = (e << 30) / d;
    if (tdam < 64'(sh_threshold)) cnt = '0;
    else if (sh_divisor == 0) cnt = 64'hFFFF_FFFF;
    else begin
      cnt = (tdam << 12) / 64'(sh_divisor);
      if (cnt < 4096) cnt = 4096;
      if (cnt > 64'hFFFF_FFFF) cnt = 64'hFFFF_FFFF;
    end
    res.damage = tdam[31:0];
    res.count = cnt[31:0];
    return res;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Safety net: far beyond the slowest legal run of this test sequence.
  initial begin
    #20ms;
    $display("lss_damage_energy_nrt_count regression: fail");
    $finish;
  end

  // Result checker: every accepted result is matched against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (damage_expect_q.size() == 0) begin
        $error("result with no request outstanding: damage %0h count %0h",
               damage_energy_o, displacements_o);
        fail_count++;
      end else begin
        dmg_result_t want;
        want = damage_expect_q.pop_front();
        if (damage_energy_o !== want.damage) begin
          $error("damage_energy expected %0h actual %0h", want.damage, damage_energy_o);
          fail_count++;
        end
        if (displacements_o !== want.count) begin
          $error("displacements expected %0h actual %0h", want.count, displacements_o);
          fail_count++;
        end
      end
      out_stall_left = idle_enable ? $urandom_range(0, 10) : 0;
    end
  end

  // The output side stalls for a freshly drawn number of cycles before each result.
  always @(negedge clk_i) begin
    if (out_stall_left > 0) begin
      out_stall_i = 1'b1;
      out_stall_left--;
    end else begin
      out_stall_i = 1'b0;
    end
  end

  // Issue one request after a random gap, and record its prediction once accepted.
  task automatic send_recoil(logic [31:0] energy);
    int gap;
    gap = idle_enable ? $urandom_range(0, 10) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    recoil_energy_i = energy;
    do @(posedge clk_i); while (in_stall_o);
    damage_expect_q.insert(damage_expect_q.size(), predict_damage(energy));
    requests_sent++;
  endtask

  // Lower the request line and let every outstanding result drain.
  task automatic drain_pipeline();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    wait (damage_expect_q.size() == 0);
  endtask

  // Register writes happen only with the pipeline empty.
  task automatic write_reg(cfg_idx_e idx, logic [39:0] value);
    drain_pipeline();
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = value;
    case (idx)
      CFG_ENERGY_FACTOR: sh_energy_factor = value;
      CFG_LOSS_FACTOR:   sh_loss_factor = value[31:0];
      CFG_THRESHOLD:     sh_threshold = value[23:0];
      CFG_NRT_DIVISOR:   sh_divisor = value[23:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic set_material(logic [39:0] ef, logic [31:0] kd, logic [23:0] thr,
                              logic [23:0] div);
    write_reg(CFG_ENERGY_FACTOR, ef);
    write_reg(CFG_LOSS_FACTOR, {8'h0, kd});
    write_reg(CFG_THRESHOLD, {16'h0, thr});
    write_reg(CFG_NRT_DIVISOR, {16'h0, div});
  endtask

  // Energies spread over many decades, plus occasional full-range values.
  function automatic logic [31:0] rand_energy();
    if ($urandom_range(0, 3) == 0) return $urandom();
    return $urandom() >> $urandom_range(0, 28);
  endfunction

  // Reset values: zero reduced energy gives Tdam = E, and the divisor is 256.
  task automatic test_reset_defaults();
    send_recoil(32'h0);
    send_recoil(32'h1);
    send_recoil(32'h100);
    send_recoil(32'h000F_FFFF);
    send_recoil(32'hFFFF_FFFF);
  endtask

  // Field extremes under a typical material, then extreme register settings.
  task automatic test_directed_extremes();
    set_material(40'd11_000_000, 32'd161_061_274, 24'd10240, 24'd25600);
    send_recoil(32'h0);
    send_recoil(32'h1);
    send_recoil(24'd10239 + 32'd0);  // Tdam just below the threshold
    send_recoil(32'd10240 << 4);
    send_recoil(32'hFFFF_FFFF);
    send_recoil(32'h8000_0000);
    // Saturated reduced energy and the largest electronic loss.
    set_material(40'hFF_FFFF_FFFF, 32'hFFFF_FFFF, 24'h0, 24'h1);
    send_recoil(32'h1);
    send_recoil(32'hFFFF_FFFF);
    send_recoil(32'h5555_5555);
    send_recoil(32'hAAAA_AAAA);
    // Zero divisor with the threshold met saturates the count.
    write_reg(CFG_NRT_DIVISOR, 40'h0);
    send_recoil(32'h0);
    send_recoil(32'h1234_5678);
    // Largest threshold: almost everything falls below it.
    set_material(40'h0, 32'h0, 24'hFF_FFFF, 24'hFF_FFFF);
    send_recoil(32'h00FF_FFFE);
    send_recoil(32'h00FF_FFFF);
    send_recoil(32'hFFFF_FFFF);
  endtask

  // Random recoils under several material settings, with a full drain mid-phase.
  task automatic test_random_materials();
    logic [39:0] ef;
    for (int ph = 0; ph < 6; ph++) begin
      ef = (ph == 0) ? 40'hFF_FFFF_FFFF : {$urandom(), 8'($urandom())} >> $urandom_range(0, 30);
      set_material(ef, $urandom() >> $urandom_range(0, 8),
                   24'($urandom() >> $urandom_range(8, 31)),
                   (ph == 1) ? 24'h0 : 24'($urandom() >> $urandom_range(8, 20)));
      idle_enable = (ph != 2);
      for (int i = 0; i < 100; i++) begin
        send_recoil(rand_energy());
        if (i == 50) drain_pipeline();
      end
    end
    idle_enable = 1'b1;
  endtask

  initial begin
    fail_count = 0;
    requests_sent = 0;
    results_seen = 0;
    out_stall_left = 0;
    idle_enable = 1'b1;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = CFG_ENERGY_FACTOR;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    recoil_energy_i = '0;
    out_stall_i = 1'b0;
    root_tab[1] = int_sqrt(64'h2000_0000_0000_0000);
    for (int k = 2; k <= 16; k++) root_tab[k] = int_sqrt(root_tab[k-1] << 30);
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_defaults();
    test_directed_extremes();
    test_random_materials();

    drain_pipeline();
    repeat (PIPE_LAT + 20) @(posedge clk_i);
    $display("Covered %0d recoil requests and %0d results over reset, extreme and random",
             requests_sent, results_seen);
    $display("material settings, with stalls and gaps on both sides.");
    if (fail_count == 0 && damage_expect_q.size() == 0) begin
      $display("lss_damage_energy_nrt_count regression: pass");
    end else begin
      $display("lss_damage_energy_nrt_count regression: fail");
    end
    $finish;
  end

endmodule
